/* hdl/fcc_pkg.sv */
// Shared types for the flagged causal convolver.
package fcc_pkg;

   // One stored sample: real part, imaginary part and bad-data flag.
   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               bad;
   } sample_type;

   // Per-cycle control for the row of history cells.
   typedef struct packed {
      logic rotate;
      logic shift;
   } cell_ctrl_type;

   // Configuration register indexes.
   localparam logic CSR_COMPLEX_MODE  = 1'b0;
   localparam logic CSR_BASE_INTERVAL = 1'b1;

endpackage

/* hdl/fcc_cell.sv */
// One history cell: holds an f sample and a g sample and passes them along the ring.
module fcc_cell (
   input  logic                  clock,
   input  fcc_pkg::cell_ctrl_type ctrl,
   input  logic                  f_we,
   input  fcc_pkg::sample_type   f_new,
   input  fcc_pkg::sample_type   g_left,
   input  fcc_pkg::sample_type   f_right,
   input  fcc_pkg::sample_type   g_right,
   output fcc_pkg::sample_type   f_q,
   output fcc_pkg::sample_type   g_q
);
   import fcc_pkg::*;

   sample_type f_ff, f_in;
   sample_type g_ff, g_in;

   // Rotation moves both samples one place headward; a shift moves g away from it.
   always_comb begin
      f_in = f_ff;
      g_in = g_ff;
      if (ctrl.rotate) begin
         f_in = f_right;
         g_in = g_right;
      end else if (ctrl.shift) begin
         g_in = g_left;
         if (f_we) begin
            f_in = f_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      f_ff <= f_in;
      g_ff <= g_in;
   end

   assign f_q = f_ff;
   assign g_q = g_ff;
endmodule

/* hdl/fcc_mac.sv */
// Weighted complex multiply-accumulate pipeline with the flag-stretched weight.
module fcc_mac #(
   parameter int MAX_POINTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                iss_valid,
   input  fcc_pkg::sample_type iss_f,
   input  fcc_pkg::sample_type iss_g,
   input  logic                complex_mode,
   input  logic [15:0]         base_interval,
   output logic signed [63:0]  sum_re,
   output logic signed [63:0]  sum_im,
   output logic                sat,
   output logic                busy
);
   import fcc_pkg::*;

   localparam int DTW = 16 + $clog2(MAX_POINTS + 1);
   localparam int TW  = 34 + DTW;

   logic [DTW-1:0] dt_ff, dt_in;
   logic                      v1_ff, v2_ff, v3_ff;
   sample_type                f1_ff, g1_ff;
   logic [DTW-1:0]            dt1_ff, dt2_ff;
   logic signed [32:0]        pr_ff, pi_ff, pr_in, pi_in;
   logic signed [31:0]        m_rr, m_ii, m_ri, m_ir;
   logic signed [TW-1:0]      wr_ff, wi_ff;
   logic signed [63:0]        acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic                      sat_ff, sat_in;
   logic signed [64:0]        s_re, s_im;

   // Weight tracking in issue order: a flagged pair stretches it, a valid one resets it.
   always_comb begin
      dt_in = dt_ff;
      if (start) begin
         dt_in = DTW'(base_interval);
      end else if (iss_valid) begin
         if (iss_f.bad || iss_g.bad) begin
            dt_in = dt_ff + DTW'(base_interval);
         end else begin
            dt_in = DTW'(base_interval);
         end
      end
   end

   // Sample products.
   always_comb begin
      m_rr  = f1_ff.re * g1_ff.re;
      m_ii  = f1_ff.im * g1_ff.im;
      m_ri  = f1_ff.re * g1_ff.im;
      m_ir  = f1_ff.im * g1_ff.re;
      pr_in = 33'(m_rr);
      pi_in = '0;
      if (complex_mode) begin
         pr_in = 33'(m_rr) - 33'(m_ii);
         pi_in = 33'(m_ri) + 33'(m_ir);
      end
   end

   // Saturating accumulation of the weighted terms.
   always_comb begin
      s_re      = 65'(acc_re_ff) + 65'(64'(wr_ff));
      s_im      = 65'(acc_im_ff) + 65'(64'(wi_ff));
      acc_re_in = s_re[63:0];
      acc_im_in = s_im[63:0];
      sat_in    = sat_ff;
      if (s_re[64] != s_re[63]) begin
         acc_re_in = s_re[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         sat_in    = 1'b1;
      end
      if (s_im[64] != s_im[63]) begin
         acc_im_in = s_im[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         sat_in    = 1'b1;
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= iss_valid && !start && !(iss_f.bad || iss_g.bad);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Pipeline payload and accumulators.
   always_ff @(posedge clock) begin
      dt_ff  <= dt_in;
      f1_ff  <= iss_f;
      g1_ff  <= iss_g;
      dt1_ff <= dt_ff;
      pr_ff  <= pr_in;
      pi_ff  <= pi_in;
      dt2_ff <= dt1_ff;
      wr_ff  <= TW'(pr_ff) * $signed({1'b0, dt2_ff});
      wi_ff  <= TW'(pi_ff) * $signed({1'b0, dt2_ff});
      if (start) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         sat_ff    <= 1'b0;
      end else if (v3_ff) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         sat_ff    <= sat_in;
      end
   end

   assign sum_re = acc_re_ff;
   assign sum_im = acc_im_ff;
   assign sat    = sat_ff;
   assign busy   = v1_ff || v2_ff || v3_ff;
endmodule

/* hdl/flagged_causal_convolver_core.sv */
// Top level of the flagged causal convolver: cell ring, sequencer and result register.
//
// Usage: each req_ transfer brings one f/g sample pair with bad flags; each
// yields exactly one rsp_ transfer holding h[y] of the current data set.
// req_first_sample starts a new set. csr_ writes set complex mode (index 0)
// and the base interval (index 1). The user must write them only while the
// block is idle; the block itself leaves this unenforced. The history lives
// in a ring of MAX_POINTS cells. For every item the ring rotates through one
// full turn, presenting one f/g pair at its head per cycle to the
// multiply-accumulate pipeline. The result is loaded into the output
// register once the turn is over and the pipeline has drained, and the
// block takes a new item only after that load. When the history is full and
// first_sample is low, the ring does not turn and the result (zeros with
// history_full set) is loaded once the pipeline has drained.
// Reset clears the sample count, the sequencer and the result valid; history
// contents are not cleared. If the receiver stalls, the result waits in the
// output register; a new item is still accepted and computed, and it is held
// back until the earlier result has been taken.
module flagged_causal_convolver_core #(
   parameter int MAX_POINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_sample,
   input  logic signed [15:0] req_f_real,
   input  logic signed [15:0] req_f_imag,
   input  logic               req_f_bad,
   input  logic signed [15:0] req_g_real,
   input  logic signed [15:0] req_g_imag,
   input  logic               req_g_bad,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_h_real,
   output logic signed [63:0] rsp_h_imag,
   output logic               rsp_saturated,
   output logic               rsp_history_full,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);
   import fcc_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, count_eff;
   logic [IW-1:0] y_ff, y_in, step_ff, step_in;
   logic          full_ff, full_in;
   logic          cmode_ff;
   logic [15:0]   base_ff;
   logic          req_xfer, start, iss_valid, busy, sat;
   logic signed [63:0] sum_re, sum_im;
   logic          rsp_valid_ff, rsp_load;
   logic signed [63:0] h_re_ff, h_im_ff;
   logic          sat_out_ff, full_out_ff;
   cell_ctrl_type ctrl;
   sample_type    f_new, g_new;
   sample_type    f_q [MAX_POINTS];
   sample_type    g_q [MAX_POINTS];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign count_eff = req_first_sample ? '0 : count_ff;
   assign f_new     = '{re: req_f_real, im: req_f_imag, bad: req_f_bad};
   assign g_new     = '{re: req_g_real, im: req_g_imag, bad: req_g_bad};
   assign start     = req_xfer;
   assign iss_valid = (state_ff == ST_RUN) && (step_ff <= y_ff);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Cell ring control: shift on a stored transfer, rotate while running.
   always_comb begin
      ctrl.shift  = req_xfer && (count_eff < CW'(MAX_POINTS));
      ctrl.rotate = (state_ff == ST_RUN);
   end

   // History ring.
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      fcc_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .f_we    (count_eff == CW'(k)),
         .f_new   (f_new),
         .g_left  ((k == 0) ? g_new : g_q[(k + MAX_POINTS - 1) % MAX_POINTS]),
         .f_right (f_q[(k + 1) % MAX_POINTS]),
         .g_right (g_q[(k + 1) % MAX_POINTS]),
         .f_q     (f_q[k]),
         .g_q     (g_q[k])
      );
   end

   fcc_mac #(.MAX_POINTS(MAX_POINTS)) u_mac (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .iss_valid     (iss_valid),
      .iss_f         (f_q[0]),
      .iss_g         (g_q[0]),
      .complex_mode  (cmode_ff),
      .base_interval (base_ff),
      .sum_re        (sum_re),
      .sum_im        (sum_im),
      .sat           (sat),
      .busy          (busy)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      y_in     = y_ff;
      step_in  = step_ff;
      full_in  = full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               step_in = '0;
               if (count_eff < CW'(MAX_POINTS)) begin
                  count_in = count_eff + 1'b1;
                  y_in     = count_eff[IW-1:0];
                  full_in  = 1'b0;
                  state_in = ST_RUN;
               end else begin
                  count_in = count_eff;
                  full_in  = 1'b1;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == IW'(MAX_POINTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cmode_ff <= 1'b0;
         base_ff  <= 16'd1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write) begin
            case (csr_index)
               CSR_COMPLEX_MODE:  cmode_ff <= csr_data[0];
               CSR_BASE_INTERVAL: base_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      step_ff <= step_in;
      full_ff <= full_in;
   end

   // Result register; a transfer frees it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         h_re_ff     <= full_ff ? '0 : sum_re;
         h_im_ff     <= full_ff ? '0 : sum_im;
         sat_out_ff  <= full_ff ? 1'b0 : sat;
         full_out_ff <= full_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_h_real       = h_re_ff;
   assign rsp_h_imag       = h_im_ff;
   assign rsp_saturated    = sat_out_ff;
   assign rsp_history_full = full_out_ff;
endmodule

/* sim/flagged_causal_convolver_checker.sv */
// Checker that predicts and compares the convolver's results.
`timescale 1ns / 100ps

module flagged_causal_convolver_checker #(
   parameter int MAX_POINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_first_sample,
   input  logic signed [15:0] req_f_real,
   input  logic signed [15:0] req_f_imag,
   input  logic               req_f_bad,
   input  logic signed [15:0] req_g_real,
   input  logic signed [15:0] req_g_imag,
   input  logic               req_g_bad,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [63:0] rsp_h_real,
   input  logic signed [63:0] rsp_h_imag,
   input  logic               rsp_saturated,
   input  logic               rsp_history_full,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   output int                 error_count,
   output int                 pending_count
);
   import fcc_pkg::*;

   typedef struct {
      logic signed [63:0] h_real;
      logic signed [63:0] h_imag;
      logic               saturated;
      logic               history_full;
   } conv_result_type;

   sample_type        f_store [MAX_POINTS];
   sample_type        g_store [MAX_POINTS];
   int                stored_pairs;
   logic              complex_on;
   logic [15:0]       interval;
   conv_result_type   expected_results [$];

   // Saturating 64-bit addition with a sticky clamp flag.
   function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
         input logic signed [63:0] b, inout logic sat);
      logic signed [64:0] wide;
      wide = 65'(a) + 65'(b);
      if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         sat = 1'b1;
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      if (wide < -65'sh0_8000_0000_0000_0000) begin
         sat = 1'b1;
         return 64'sh8000_0000_0000_0000;
      end
      return wide[63:0];
   endfunction

   // Store the pair and compute h[y] with the flag-stretched weight.
   function automatic conv_result_type convolve_pair(input logic first,
         input sample_type f_in, input sample_type g_in);
      conv_result_type   r;
      logic signed [63:0] pr, pi, dt;
      sample_type        a, b;
      int                y;
      r = '{64'sd0, 64'sd0, 1'b0, 1'b0};
      if (first) stored_pairs = 0;
      if (stored_pairs >= MAX_POINTS) begin
         r.history_full = 1'b1;
         return r;
      end
      y = stored_pairs;
      f_store[y] = f_in;
      g_store[y] = g_in;
      stored_pairs = y + 1;
      dt = 64'(interval);
      for (int x = 0; x <= y; x++) begin
         a = f_store[x];
         b = g_store[y - x];
         if (a.bad || b.bad) begin
            dt = dt + 64'(interval);
         end else begin
            if (complex_on) begin
               pr = 64'(a.re) * 64'(b.re) - 64'(a.im) * 64'(b.im);
               pi = 64'(a.re) * 64'(b.im) + 64'(a.im) * 64'(b.re);
            end else begin
               pr = 64'(a.re) * 64'(b.re);
               pi = 0;
            end
            r.h_real = clamp_add(r.h_real, pr * dt, r.saturated);
            r.h_imag = clamp_add(r.h_imag, pi * dt, r.saturated);
            dt = 64'(interval);
         end
      end
      return r;
   endfunction

   // Track register writes, predict on each input transfer, check each result transfer.
   always @(posedge clock) begin
      conv_result_type want;
      if (reset) begin
         stored_pairs = 0;
         complex_on = 1'b0;
         interval = 16'd1;
         expected_results.delete();
         error_count = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_COMPLEX_MODE) complex_on = csr_data[0];
            else interval = csr_data;
         end
         if (req_valid && !req_stall)
            expected_results.push_back(convolve_pair(req_first_sample,
               '{req_f_real, req_f_imag, req_f_bad}, '{req_g_real, req_g_imag, req_g_bad}));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with no expectation", $time);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_h_real !== want.h_real) begin
                  $display("%0t: h_real expected %0d actual %0d", $time, want.h_real, rsp_h_real);
                  error_count++;
               end
               if (rsp_h_imag !== want.h_imag) begin
                  $display("%0t: h_imag expected %0d actual %0d", $time, want.h_imag, rsp_h_imag);
                  error_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                     rsp_saturated);
                  error_count++;
               end
               if (rsp_history_full !== want.history_full) begin
                  $display("%0t: history_full expected %0b actual %0b", $time,
                     want.history_full, rsp_history_full);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_results.size();
   end
endmodule

/* sim/flagged_causal_convolver_core_test.sv */
// Testbench top: stimulus, idling, register phases and the verdict.
`timescale 1ns / 100ps

module flagged_causal_convolver_core_test;
   import fcc_pkg::*;

   localparam int MAX_POINTS = 64;
   localparam int IDLE_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_first_sample = 1'b0;
   logic signed [15:0] req_f_real = '0;
   logic signed [15:0] req_f_imag = '0;
   logic               req_f_bad = 1'b0;
   logic signed [15:0] req_g_real = '0;
   logic signed [15:0] req_g_imag = '0;
   logic               req_g_bad = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_h_real;
   logic signed [63:0] rsp_h_imag;
   logic               rsp_saturated;
   logic               rsp_history_full;
   logic               csr_write = 1'b0;
   logic               csr_index = CSR_COMPLEX_MODE;
   logic [15:0]        csr_data = '0;
   int                 error_count;
   int                 pending_count;
   int                 quiet_cycles = 0;
   bit                 steady_phase = 1'b0;
   bit                 hold_off_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   flagged_causal_convolver_core #(.MAX_POINTS(MAX_POINTS)) dut (.*);

   flagged_causal_convolver_checker #(.MAX_POINTS(MAX_POINTS)) checker_inst (.*);

   // Watchdog: count cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver stalls: random, none in the steady phase, one long hold-off on request.
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (1200) @(negedge clock);
            hold_off_request = 1'b0;
         end
         rsp_stall <= !steady_phase && ($urandom_range(99) < 19);
         @(negedge clock);
      end
   end

   task automatic write_register(input logic index, input logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Offer one pair and wait for its transfer, with random gaps before it.
   task automatic send_pair(input logic first, input logic [15:0] fr, input logic [15:0] fi,
         input logic fb, input logic [15:0] gr, input logic [15:0] gi, input logic gb);
      while (!steady_phase && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_sample <= first;
      req_f_real <= fr;
      req_f_imag <= fi;
      req_f_bad <= fb;
      req_g_real <= gr;
      req_g_imag <= gi;
      req_g_bad <= gb;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Wait until every expected result has come, then let the block settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (MAX_POINTS + 10) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_value;
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(7));
         default: return 16'($urandom);
      endcase
   endfunction

   // One data set of random content; bad flags occasional.
   task automatic random_set(input int length, input int bad_pct);
      for (int i = 0; i < length; i++)
         send_pair(i == 0, pick_value(), pick_value(), $urandom_range(99) < bad_pct,
            pick_value(), pick_value(), $urandom_range(99) < bad_pct);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, flags, mode and saturation, starting at reset settings.
      send_pair(1, 16'h8000, 16'h8000, 0, 16'h8000, 16'h8000, 0);
      send_pair(0, 16'h7FFF, 16'h7FFF, 1, 16'h8000, 16'h7FFF, 0);
      send_pair(0, 16'h7FFF, 16'h8000, 0, 16'h7FFF, 16'h8000, 1);
      send_pair(0, 16'h0001, 16'hFFFF, 1, 16'hFFFF, 16'h0001, 1);
      send_pair(0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 0);
      drain();
      write_register(CSR_COMPLEX_MODE, 16'd1);
      write_register(CSR_BASE_INTERVAL, 16'hFFFF);
      send_pair(1, 16'h8000, 16'h8000, 0, 16'h8000, 16'h8000, 0);
      send_pair(0, 16'h8000, 16'h7FFF, 1, 16'h7FFF, 16'h8000, 0);
      send_pair(0, 16'h8000, 16'h8000, 0, 16'h8000, 16'h8000, 0);
      send_pair(0, 16'h7FFF, 16'h8000, 0, 16'h8000, 16'h7FFF, 0);
      drain();
      write_register(CSR_BASE_INTERVAL, 16'd0);
      send_pair(1, 16'h7FFF, 16'h1234, 0, 16'h7FFF, 16'hEDCB, 0);
      send_pair(0, 16'h4000, 16'h4000, 0, 16'h4000, 16'h4000, 1);
      drain();

      // Full history, then pairs beyond it, in complex mode at the largest base interval.
      write_register(CSR_BASE_INTERVAL, 16'hFFFF);
      random_set(MAX_POINTS + 3, 10);
      drain();

      // Random phases over several settings, with a steady stretch and a long hold-off.
      for (int phase = 0; phase < 8; phase++) begin
         write_register(CSR_COMPLEX_MODE, 16'(phase[0]));
         case (phase)
            0: write_register(CSR_BASE_INTERVAL, 16'd1);
            1: write_register(CSR_BASE_INTERVAL, 16'hFFFF);
            2: write_register(CSR_BASE_INTERVAL, 16'd0);
            default: write_register(CSR_BASE_INTERVAL, 16'($urandom_range(1, 65535)));
         endcase
         steady_phase = (phase == 3);
         if (phase == 5) hold_off_request = 1'b1;
         for (int n = 0; n < 180; ) begin
            int length;
            length = ($urandom_range(9) == 0) ? $urandom_range(MAX_POINTS - 4, MAX_POINTS + 4)
                                              : $urandom_range(1, 16);
            if ($urandom_range(9) == 0)
               send_pair(1'($urandom_range(1)), pick_value(), pick_value(),
                  1'($urandom_range(1)), pick_value(), pick_value(), 1'($urandom_range(1)));
            else
               random_set(length, 15);
            n += length;
         end
         steady_phase = 1'b0;
         drain();
      end

      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
